@@ hw/rtl/lj_pkg.sv @@
// ----------------------------------------------------------------------------
// lj_pkg
// Shared types, constants and fixed-point helpers of the LJ pair force block.
// ----------------------------------------------------------------------------
package lj_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_BITS  = 24;
  localparam int BOX_BITS  = 24;
  localparam int QW        = 63 - FRAC_BITS;       // width of capped products
  localparam int QLO       = 24;                   // low slice of a product operand
  localparam int QHI       = QW - QLO;             // high slice of a product operand
  localparam int MW        = POS_BITS + 2;         // displacement magnitude
  localparam int WW        = POS_BITS + 4;         // signed wrap arithmetic
  localparam int DW        = FRAC_BITS + 32;       // dividend width
  localparam logic [QW-1:0] QCAP = {QW{1'b1}};

  localparam logic [1:0] ST_BEYOND = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  localparam logic [2:0] REG_BOX_X        = 3'd0;
  localparam logic [2:0] REG_BOX_Y        = 3'd1;
  localparam logic [2:0] REG_BOX_Z        = 3'd2;
  localparam logic [2:0] REG_CUTOFF_SQ    = 3'd3;
  localparam logic [2:0] REG_SIGMA_SQ     = 3'd4;
  localparam logic [2:0] REG_WELL_DEPTH   = 3'd5;
  localparam logic [2:0] REG_ENERGY_SHIFT = 3'd6;

  typedef struct packed {
    logic [POS_BITS-1:0] first_x;
    logic [POS_BITS-1:0] first_y;
    logic [POS_BITS-1:0] first_z;
    logic [POS_BITS-1:0] second_x;
    logic [POS_BITS-1:0] second_y;
    logic [POS_BITS-1:0] second_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] pair_energy;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [BOX_BITS-1:0] box_x;
    logic [BOX_BITS-1:0] box_y;
    logic [BOX_BITS-1:0] box_z;
    logic [31:0]         cutoff_sq;
    logic [31:0]         sigma_sq;
    logic [23:0]         well_depth;
    logic signed [31:0]  energy_shift;
  } cfg_t;

  // per-pair data that rides along with the distance
  typedef struct packed {
    logic [1:0]    status;
    logic [MW-1:0] mx;
    logic [MW-1:0] my;
    logic [MW-1:0] mz;
    logic          nx;
    logic          ny;
    logic          nz;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] r2;
  } pair_t;

  // four partial products of one capped product
  typedef struct packed {
    logic [2*QLO-1:0]   ll;
    logic [QLO+QHI-1:0] lh;
    logic [QLO+QHI-1:0] hl;
    logic [2*QHI-1:0]   hh;
  } qpp_t;

  function automatic qpp_t qmul_pp(input logic [QW-1:0] a, input logic [QW-1:0] b);
    qmul_pp.ll = a[QLO-1:0] * b[QLO-1:0];
    qmul_pp.lh = a[QLO-1:0] * b[QW-1:QLO];
    qmul_pp.hl = a[QW-1:QLO] * b[QLO-1:0];
    qmul_pp.hh = a[QW-1:QLO] * b[QW-1:QLO];
  endfunction

  function automatic logic [QW-1:0] qmul_sum(input qpp_t pp);
    logic [2*QW-1:0] p;
    logic [2*QW-1:0] sh;
    p  = (2*QW)'(pp.ll) + ((2*QW)'(pp.lh) << QLO) + ((2*QW)'(pp.hl) << QLO) +
         ((2*QW)'(pp.hh) << (2*QLO));
    sh = p >> FRAC_BITS;
    if (sh > (2*QW)'(QCAP)) qmul_sum = QCAP;
    else qmul_sum = sh[QW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic neg, input logic [QW:0] mag);
    if (neg) begin
      if (mag >= (QW+1)'(64'h8000_0000)) sat32 = 32'sh8000_0000;
      else sat32 = -$signed(mag[31:0]);
    end else begin
      if (mag >= (QW+1)'(64'h8000_0000)) sat32 = 32'sh7fff_ffff;
      else sat32 = $signed(mag[31:0]);
    end
  endfunction

endpackage

@@ hw/rtl/lennard_jones_pair_force_top.sv @@
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_top
// 12-6 Lennard-Jones pair force and shifted energy in a periodic box.
// ----------------------------------------------------------------------------
// One atom pair is taken per clock and one result word leaves per clock once
// the pipeline is full and the output is not stalled. A result word passes
// two front stages (wrap, squared distance), the four-entry queue, 48 stages
// of the shared restoring divider that forms sigma^2/r2 and 1/r2, twelve
// product stages (each product is built as partial products in one stage and
// summed in the next) and the output register. Output stalls hold the whole
// force pipeline; the queue and front keep taking pairs until the queue fills.
module lennard_jones_pair_force_top import lj_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  cfg_t  cfg;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  pair_valid;
  pair_t pair;
  pair_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x        <= 24'd1378877;
      cfg.box_y        <= 24'd1378877;
      cfg.box_z        <= 24'd1378877;
      cfg.cutoff_sq    <= 32'd5029059;
      cfg.sigma_sq     <= 32'd804664;
      cfg.well_depth   <= 24'd15335;
      cfg.energy_shift <= -32'sd250;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BOX_X:        cfg.box_x        <= cfg_wr_data[23:0];
        REG_BOX_Y:        cfg.box_y        <= cfg_wr_data[23:0];
        REG_BOX_Z:        cfg.box_z        <= cfg_wr_data[23:0];
        REG_CUTOFF_SQ:    cfg.cutoff_sq    <= cfg_wr_data;
        REG_SIGMA_SQ:     cfg.sigma_sq     <= cfg_wr_data;
        REG_WELL_DEPTH:   cfg.well_depth   <= cfg_wr_data[23:0];
        REG_ENERGY_SHIFT: cfg.energy_shift <= $signed(cfg_wr_data);
        default: ;
      endcase
    end
  end

  lj_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .q_full     (q_full),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  lj_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (pair_valid),
    .push_data (pair),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  lj_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ hw/rtl/lj_front.sv @@
// ----------------------------------------------------------------------------
// lj_front
// Minimum-image wrap, squared distance and zero/cutoff classification.
// ----------------------------------------------------------------------------
module lj_front import lj_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     pair_valid,
  output pair_t    pair
);

  logic          en;
  logic          s1_valid;
  logic [MW-1:0] m1 [0:2];
  logic          n1 [0:2];
  logic [MW-1:0] mc [0:2];
  logic          nc [0:2];

  function automatic logic [WW-1:0] wrap_d(input logic [POS_BITS-1:0] a,
                                           input logic [POS_BITS-1:0] b,
                                           input logic [BOX_BITS-1:0] len);
    logic signed [WW-1:0] d;
    logic signed [WW-1:0] l;
    d = $signed({4'b0, a}) - $signed({4'b0, b});
    l = $signed({{(WW-BOX_BITS){1'b0}}, len});
    if ((d <<< 1) > l) d = d - l;
    else if ((d <<< 1) < -l) d = d + l;
    wrap_d = d;
  endfunction

  always_comb begin
    logic [WW-1:0] d [0:2];
    d[0] = wrap_d(in_item.first_x, in_item.second_x, cfg.box_x);
    d[1] = wrap_d(in_item.first_y, in_item.second_y, cfg.box_y);
    d[2] = wrap_d(in_item.first_z, in_item.second_z, cfg.box_z);
    for (int k = 0; k < 3; k++) begin
      nc[k] = d[k][WW-1];
      mc[k] = nc[k] ? MW'(-d[k]) : MW'(d[k]);
    end
  end

  assign en       = !pair_valid || !q_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pair_valid <= 1'b0;
    end else if (en) begin
      s1_valid   <= in_valid;
      pair_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [2*MW+1:0] sum;
    logic [2*MW+1:0] r2f;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m1[k] <= mc[k];
        n1[k] <= nc[k];
      end
      sum = (2*MW+2)'(m1[0] * m1[0]) + (2*MW+2)'(m1[1] * m1[1]) +
            (2*MW+2)'(m1[2] * m1[2]);
      r2f = sum >> FRAC_BITS;
      if (r2f == '0) pair.side.status <= ST_ZERO;
      else if (r2f >= (2*MW+2)'(cfg.cutoff_sq)) pair.side.status <= ST_BEYOND;
      else pair.side.status <= ST_HIT;
      pair.r2      <= r2f[31:0];
      pair.side.mx <= m1[0];
      pair.side.my <= m1[1];
      pair.side.mz <= m1[2];
      pair.side.nx <= n1[0];
      pair.side.ny <= n1[1];
      pair.side.nz <= n1[2];
    end
  end

endmodule

@@ hw/rtl/lj_fifo.sv @@
// ----------------------------------------------------------------------------
// lj_fifo
// Four-entry queue between the front and the force pipeline.
// ----------------------------------------------------------------------------
module lj_fifo import lj_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  pair_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output pair_t pop_data
);

  pair_t      mem [0:3];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 2'd1;
      if (do_pop) rptr <= rptr + 2'd1;
      count <= count + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_data;
  end

endmodule

@@ hw/rtl/lj_div.sv @@
// ----------------------------------------------------------------------------
// lj_div
// Pipelined restoring divider, one quotient bit per stage, two dividends
// over one shared divisor.
// ----------------------------------------------------------------------------
module lj_div import lj_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] num_a,
  input  logic [DW-1:0] num_b,
  input  logic [31:0]   divisor,
  input  side_t         in_side,
  output logic          out_valid,
  output logic [DW-1:0] quo_a,
  output logic [DW-1:0] quo_b,
  output side_t         out_side
);

  logic          v  [0:DW];
  logic [DW-1:0] na [0:DW];
  logic [DW-1:0] nb [0:DW];
  logic [DW-1:0] qa [0:DW];
  logic [DW-1:0] qb [0:DW];
  logic [31:0]   ra [0:DW];
  logic [31:0]   rb [0:DW];
  logic [31:0]   dv [0:DW];
  side_t         sd [0:DW];

  assign v[0]  = in_valid;
  assign na[0] = num_a;
  assign nb[0] = num_b;
  assign qa[0] = '0;
  assign qb[0] = '0;
  assign ra[0] = '0;
  assign rb[0] = '0;
  assign dv[0] = divisor;
  assign sd[0] = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [32:0] ta;
    logic [32:0] tb;
    logic        ga;
    logic        gb;

    always_comb begin
      ta = {ra[i], na[i][DW-1]};
      tb = {rb[i], nb[i][DW-1]};
      ga = (ta >= {1'b0, dv[i]});
      gb = (tb >= {1'b0, dv[i]});
    end

    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (en) v[i+1] <= v[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        na[i+1] <= na[i] << 1;
        nb[i+1] <= nb[i] << 1;
        qa[i+1] <= {qa[i][DW-2:0], ga};
        qb[i+1] <= {qb[i][DW-2:0], gb};
        ra[i+1] <= ga ? 32'(ta - {1'b0, dv[i]}) : ta[31:0];
        rb[i+1] <= gb ? 32'(tb - {1'b0, dv[i]}) : tb[31:0];
        dv[i+1] <= dv[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = v[DW];
  assign quo_a     = qa[DW];
  assign quo_b     = qb[DW];
  assign out_side  = sd[DW];

endmodule

@@ hw/rtl/lj_back.sv @@
// ----------------------------------------------------------------------------
// lj_back
// Force and energy pipeline: divisions, sixth-power chain, scaling and
// saturation into the output register.
// ----------------------------------------------------------------------------
module lj_back import lj_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  pair_t     q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int NST = 12;

  logic          en;
  logic          dv_valid;
  logic [DW-1:0] qs;
  logic [DW-1:0] qr;
  side_t         dv_side;
  logic [QW-1:0] s_clip;

  logic [NST-1:0] vp;
  side_t          sp [0:NST-1];

  logic [QW-1:0] s_a1, s_a2, ss_a2, r6i_b2, r6i_c, ma_c, me_c;
  logic [QW-1:0] p1_d2, q1_d2, p2_e2, u_e2, t_f2;
  logic [QW-1:0] r2i_a1, r2i_a2, r2i_b1, r2i_b2, r2i_c, r2i_d1, r2i_d2, r2i_e1, r2i_e2;
  logic          fneg_c, fneg_d1, fneg_d2, fneg_e1, fneg_e2, fneg_f1, fneg_f2, fneg_g1;
  logic          eneg_c, eneg_d1, eneg_d2, eneg_e1, eneg_e2;
  qpp_t          pp_ss, pp_r6, pp_p1, pp_q1, pp_p2, pp_u, pp_t;
  qpp_t          pp_fm [0:2];
  logic signed [31:0] eng_f1, eng_f2, eng_g1;

  localparam logic [QW-1:0] HALF = QW'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0] ONE  = QW'(1) << FRAC_BITS;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  lj_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (!q_empty),
    .num_a     ({cfg.sigma_sq, FRAC_BITS'(0)}),
    .num_b     (DW'(1) << (2 * FRAC_BITS)),
    .divisor   (q_data.r2),
    .in_side   (q_data.side),
    .out_valid (dv_valid),
    .quo_a     (qs),
    .quo_b     (qr),
    .out_side  (dv_side)
  );

  assign s_clip = (qs > DW'(QCAP)) ? QCAP : qs[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vp        <= {vp[NST-2:0], dv_valid};
      out_valid <= vp[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp[0] <= dv_side;
      for (int k = 1; k < NST; k++) sp[k] <= sp[k-1];
    end
  end

  // every product takes two stages: partial products, then their sum
  always_ff @(posedge clk) begin
    logic [QW:0]          u_sgn;
    logic signed [QW+2:0] e;
    logic [QW-1:0]        fm [0:2];
    if (en) begin
      // squares of sigma over r
      s_a1   <= s_clip;
      r2i_a1 <= (qr > DW'(QCAP)) ? QCAP : qr[QW-1:0];
      pp_ss  <= qmul_pp(s_clip, s_clip);
      s_a2   <= s_a1;
      r2i_a2 <= r2i_a1;
      ss_a2  <= qmul_sum(pp_ss);
      // sixth power
      pp_r6  <= qmul_pp(ss_a2, s_a2);
      r2i_b1 <= r2i_a2;
      r6i_b2 <= qmul_sum(pp_r6);
      r2i_b2 <= r2i_b1;
      // signed offsets of the force and energy brackets
      r6i_c  <= r6i_b2;
      r2i_c  <= r2i_b2;
      fneg_c <= r6i_b2 < HALF;
      ma_c   <= (r6i_b2 < HALF) ? HALF - r6i_b2 : r6i_b2 - HALF;
      eneg_c <= r6i_b2 < ONE;
      me_c   <= (r6i_b2 < ONE) ? ONE - r6i_b2 : r6i_b2 - ONE;
      pp_p1   <= qmul_pp(r6i_c, ma_c);
      pp_q1   <= qmul_pp(r6i_c, me_c);
      r2i_d1  <= r2i_c;
      fneg_d1 <= fneg_c;
      eneg_d1 <= eneg_c;
      p1_d2   <= qmul_sum(pp_p1);
      q1_d2   <= qmul_sum(pp_q1);
      r2i_d2  <= r2i_d1;
      fneg_d2 <= fneg_d1;
      eneg_d2 <= eneg_d1;
      pp_p2   <= qmul_pp(p1_d2, QW'(cfg.well_depth) * QW'(48));
      pp_u    <= qmul_pp(q1_d2, QW'(cfg.well_depth) * QW'(4));
      r2i_e1  <= r2i_d2;
      fneg_e1 <= fneg_d2;
      eneg_e1 <= eneg_d2;
      p2_e2   <= qmul_sum(pp_p2);
      u_e2    <= qmul_sum(pp_u);
      r2i_e2  <= r2i_e1;
      fneg_e2 <= fneg_e1;
      eneg_e2 <= eneg_e1;
      // force factor and shifted energy
      pp_t    <= qmul_pp(p2_e2, r2i_e2);
      fneg_f1 <= fneg_e2;
      u_sgn   = {1'b0, u_e2};
      e = eneg_e2 ? -$signed({2'b0, u_sgn}) : $signed({2'b0, u_sgn});
      e = e - (QW+3)'(cfg.energy_shift);
      eng_f1  <= sat32(e[QW+2], e[QW+2] ? (QW+1)'(-e) : e[QW:0]);
      t_f2    <= qmul_sum(pp_t);
      fneg_f2 <= fneg_f1;
      eng_f2  <= eng_f1;
      // force components
      pp_fm[0] <= qmul_pp(t_f2, QW'(sp[NST-2].mx));
      pp_fm[1] <= qmul_pp(t_f2, QW'(sp[NST-2].my));
      pp_fm[2] <= qmul_pp(t_f2, QW'(sp[NST-2].mz));
      fneg_g1  <= fneg_f2;
      eng_g1   <= eng_f2;
      for (int k = 0; k < 3; k++) fm[k] = qmul_sum(pp_fm[k]);
      out_item.status <= sp[NST-1].status;
      if (sp[NST-1].status == ST_HIT) begin
        out_item.force_x     <= sat32(fneg_g1 != sp[NST-1].nx, {1'b0, fm[0]});
        out_item.force_y     <= sat32(fneg_g1 != sp[NST-1].ny, {1'b0, fm[1]});
        out_item.force_z     <= sat32(fneg_g1 != sp[NST-1].nz, {1'b0, fm[2]});
        out_item.pair_energy <= eng_g1;
      end else begin
        out_item.force_x     <= '0;
        out_item.force_y     <= '0;
        out_item.force_z     <= '0;
        out_item.pair_energy <= '0;
      end
    end
  end

endmodule
